### src/uue_pkg.sv
// ----------------------------------------------------------------------------
// uue_pkg
// shared types, microcode program and character helpers for the uuencode
// line encoder
// ----------------------------------------------------------------------------
package uue_pkg;

  localparam int LINE_BYTES_DEF = 45;
  localparam int HDR_LEN        = 16;
  localparam int PC_W           = 5;
  localparam int CFG_ADDR_W     = 3;

  // register indexes on the configuration port
  localparam logic REG_HDR_EN    = 1'b0;
  localparam logic REG_LOAD_ADDR = 1'b1;

  localparam logic REQ_EOS = 1'b1;

  // fixed characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_GRAVE = 8'h60;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_EOF   = 8'h1a;
  localparam logic [7:0] CH_BIAS  = 8'h20;

  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR  = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_START, OP_WR_HDR, OP_WR_DATA, OP_FINISH, OP_END_STREAM,
    OP_RD_CLEAR, OP_RD_NEXT, OP_CAP0, OP_CAP1, OP_CAP2, OP_CLR_COUNT
  } op_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_LEN, EM_GROUP, EM_CRLF, EM_TRL1, EM_TRL2, EM_TRL3
  } emit_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_NO_INPUT, C_STARTED, C_HDR_OFF, C_FULL, C_HDR_MORE, C_IS_EOS,
    C_HAS_BYTES, C_MORE_GROUPS
  } cond_t;

  typedef enum logic [1:0] {
    J_NEXT, J_JUMP, J_CALL, J_RET
  } jmode_t;

  typedef struct packed {
    op_t             op;
    emit_t           emit;
    cond_t           cond;
    jmode_t          jmode;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic started;
    logic hdr_off;
    logic full;
    logic hdr_more;
    logic is_eos;
    logic has_bytes;
    logic more_groups;
    logic blocked;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [2:0] count;
  } res_t;

  // program addresses
  localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] S_CHK     = 5'd1;
  localparam logic [PC_W-1:0] S_START   = 5'd2;
  localparam logic [PC_W-1:0] S_HCHK    = 5'd3;
  localparam logic [PC_W-1:0] S_HPUSH   = 5'd4;
  localparam logic [PC_W-1:0] S_HFULL   = 5'd5;
  localparam logic [PC_W-1:0] S_HNEXT   = 5'd6;
  localparam logic [PC_W-1:0] S_DISP    = 5'd7;
  localparam logic [PC_W-1:0] S_DPUSH   = 5'd8;
  localparam logic [PC_W-1:0] S_DFULL   = 5'd9;
  localparam logic [PC_W-1:0] S_FIN     = 5'd10;
  localparam logic [PC_W-1:0] S_EOS     = 5'd11;
  localparam logic [PC_W-1:0] S_TRL1    = 5'd12;
  localparam logic [PC_W-1:0] S_TRL2    = 5'd13;
  localparam logic [PC_W-1:0] S_TRL3    = 5'd14;
  localparam logic [PC_W-1:0] S_FLUSH   = 5'd15;
  localparam logic [PC_W-1:0] S_RD0     = 5'd16;
  localparam logic [PC_W-1:0] S_CAP0    = 5'd17;
  localparam logic [PC_W-1:0] S_CAP1    = 5'd18;
  localparam logic [PC_W-1:0] S_CAP2    = 5'd19;
  localparam logic [PC_W-1:0] S_GROUP   = 5'd20;
  localparam logic [PC_W-1:0] S_CRLF    = 5'd21;

  function automatic uword_t mk(input op_t op, input emit_t em, input cond_t cd,
                                input jmode_t jm, input logic [PC_W-1:0] tgt);
    uword_t w;
    w.op     = op;
    w.emit   = em;
    w.cond   = cd;
    w.jmode  = jm;
    w.target = tgt;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_IDLE:  w = mk(OP_ACCEPT,     EM_NONE,  C_NO_INPUT,    J_JUMP, S_IDLE);
      S_CHK:   w = mk(OP_NONE,       EM_NONE,  C_STARTED,     J_JUMP, S_DISP);
      S_START: w = mk(OP_START,      EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_HCHK:  w = mk(OP_NONE,       EM_NONE,  C_HDR_OFF,     J_JUMP, S_DISP);
      S_HPUSH: w = mk(OP_WR_HDR,     EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_HFULL: w = mk(OP_NONE,       EM_NONE,  C_FULL,        J_CALL, S_FLUSH);
      S_HNEXT: w = mk(OP_NONE,       EM_NONE,  C_HDR_MORE,    J_JUMP, S_HPUSH);
      S_DISP:  w = mk(OP_NONE,       EM_NONE,  C_IS_EOS,      J_JUMP, S_EOS);
      S_DPUSH: w = mk(OP_WR_DATA,    EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_DFULL: w = mk(OP_NONE,       EM_NONE,  C_FULL,        J_CALL, S_FLUSH);
      S_FIN:   w = mk(OP_FINISH,     EM_NONE,  C_ALWAYS,      J_JUMP, S_IDLE);
      S_EOS:   w = mk(OP_NONE,       EM_NONE,  C_HAS_BYTES,   J_CALL, S_FLUSH);
      S_TRL1:  w = mk(OP_NONE,       EM_TRL1,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_TRL2:  w = mk(OP_NONE,       EM_TRL2,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_TRL3:  w = mk(OP_END_STREAM, EM_TRL3,  C_ALWAYS,      J_JUMP, S_FIN);
      S_FLUSH: w = mk(OP_RD_CLEAR,   EM_LEN,   C_ALWAYS,      J_NEXT, S_IDLE);
      S_RD0:   w = mk(OP_RD_NEXT,    EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_CAP0:  w = mk(OP_CAP0,       EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_CAP1:  w = mk(OP_CAP1,       EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_CAP2:  w = mk(OP_CAP2,       EM_NONE,  C_ALWAYS,      J_NEXT, S_IDLE);
      S_GROUP: w = mk(OP_NONE,       EM_GROUP, C_MORE_GROUPS, J_JUMP, S_RD0);
      S_CRLF:  w = mk(OP_CLR_COUNT,  EM_CRLF,  C_ALWAYS,      J_RET,  S_IDLE);
      default: w = mk(OP_NONE,       EM_NONE,  C_ALWAYS,      J_JUMP, S_IDLE);
    endcase
    return w;
  endfunction

  // load header byte, address low bytes patched in at bytes 5 and 6
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] addr);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hff;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h06;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h10;
      4'd5:    b = addr[7:0];
      4'd6:    b = addr[15:8];
      4'd10:   b = 8'h0b;
      4'd11:   b = 8'hff;
      4'd12:   b = 8'hff;
      4'd13:   b = 8'hff;
      4'd15:   b = 8'h0f;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // 6-bit value to printable character, zero maps to grave accent
  function automatic logic [7:0] enc6(input logic [5:0] v);
    return (v == 6'd0) ? CH_GRAVE : ({2'b00, v} + CH_BIAS);
  endfunction

endpackage

### src/uuencode_line_encoder_core.sv
// ----------------------------------------------------------------------------
// uuencode_line_encoder_core
// byte stream to uuencoded lines, with optional binary load header and
// end-of-stream trailer
// ----------------------------------------------------------------------------
// Each input transaction is a data byte or an end-of-stream marker; each
// output transaction carries one to four characters and final_of_run flags
// the last one caused by an input transaction (a byte that does not complete
// a line causes none). Control is a 22-step microprogram that runs one step
// per clock unless a stalled output blocks it, over a line buffer with one
// write and one read port, which set the timing: a data byte is written and
// the line checked before the next byte is accepted; a line flush emits the
// length character, reads each group of three bytes and emits its four
// characters, then CR LF; a stream start adds header writes with the header
// mode on; and an end of stream adds any flush and the three trailer
// results. The last result of a transaction is held in the pending register
// until the program knows it is the last, and a waiting output does not
// hold off the next input transaction; only a further result, or the end of
// a transaction with a result held, while the output is still stalled makes
// the program wait.
// Configuration writes go through the APB-style port at any time the block
// is idle; header_enable and load_address are sampled when a stream starts.
// ----------------------------------------------------------------------------
module uuencode_line_encoder_core
  import uue_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [7:0]            in_data_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char_a,
  output logic [7:0]            out_char_b,
  output logic [7:0]            out_char_c,
  output logic [7:0]            out_char_d,
  output logic [2:0]            out_char_count,
  output logic                  out_final_of_run
);

  logic        hdr_en_r;
  logic [19:0] load_addr_r;
  logic        cfg_wr;
  logic        cfg_sel;

  uword_t      uword;
  dp_status_t  status;
  res_t        out_res;

  // register index sits at paddr bit 2, byte lanes ignored
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_en_r    <= 1'b0;
      load_addr_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_HDR_EN:    hdr_en_r    <= cfg_pwdata[0];
        REG_LOAD_ADDR: load_addr_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_HDR_EN:    cfg_prdata = {31'd0, hdr_en_r};
      REG_LOAD_ADDR: cfg_prdata = {12'd0, load_addr_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // sequencer: program counter and control store
  uue_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .uword  (uword)
  );

  // datapath: line buffer, encoder and result registers
  // only the low 16 address bits reach the header
  uue_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .uword        (uword),
    .status       (status),
    .cfg_hdr_en   (hdr_en_r),
    .cfg_addr     (load_addr_r[15:0]),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (out_res),
    .out_final    (out_final_of_run)
  );

  assign out_char_a     = out_res.a;
  assign out_char_b     = out_res.b;
  assign out_char_c     = out_res.c;
  assign out_char_d     = out_res.d;
  assign out_char_count = out_res.count;

endmodule

### src/uue_ram.sv
// ----------------------------------------------------------------------------
// uue_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module uue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/uue_ctrl.sv
// ----------------------------------------------------------------------------
// uue_ctrl
// microcode sequencer: step counter, one-level link register, condition
// select and control store lookup
// ----------------------------------------------------------------------------
module uue_ctrl
  import uue_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t status,
  output uword_t     uword
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] link_r, link_nxt;
  logic [PC_W-1:0] pc_inc;
  logic            cond_true;

  assign uword  = ucode_rom(pc_r);
  assign pc_inc = pc_r + PC_W'(1);

  always_comb begin
    case (uword.cond)
      C_ALWAYS:      cond_true = 1'b1;
      C_NO_INPUT:    cond_true = !status.in_valid;
      C_STARTED:     cond_true = status.started;
      C_HDR_OFF:     cond_true = status.hdr_off;
      C_FULL:        cond_true = status.full;
      C_HDR_MORE:    cond_true = status.hdr_more;
      C_IS_EOS:      cond_true = status.is_eos;
      C_HAS_BYTES:   cond_true = status.has_bytes;
      C_MORE_GROUPS: cond_true = status.more_groups;
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    link_nxt = link_r;
    if (!status.blocked) begin
      case (uword.jmode)
        J_NEXT: pc_nxt = pc_inc;
        J_JUMP: pc_nxt = cond_true ? uword.target : pc_inc;
        J_CALL: begin
          pc_nxt = cond_true ? uword.target : pc_inc;
          if (cond_true) begin
            link_nxt = pc_inc;
          end
        end
        J_RET:   pc_nxt = link_r;
        default: pc_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= S_IDLE;
      link_r <= S_IDLE;
    end else begin
      pc_r   <= pc_nxt;
      link_r <= link_nxt;
    end
  end

endmodule

### src/uue_datapath.sv
// ----------------------------------------------------------------------------
// uue_datapath
// line buffer, counters, group assembly, character encoding and the
// pending/output result registers, all driven by the current control word
// ----------------------------------------------------------------------------
module uue_datapath
  import uue_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  uword_t      uword,
  output dp_status_t  status,
  input  logic        cfg_hdr_en,
  input  logic [15:0] cfg_addr,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res,
  output logic        out_final
);

  localparam int IDX_W = $clog2(LINE_BYTES);
  localparam int CNT_W = $clog2(LINE_BYTES + 3);

  localparam logic [CNT_W-1:0] LINE_CNT = CNT_W'(LINE_BYTES);

  logic             started_r;
  logic             hdr_en_r;
  logic [15:0]      addr_r;
  logic [3:0]       hdr_idx_r;
  logic             req_r;
  logic [7:0]       data_r;
  logic [CNT_W-1:0] byte_count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_ok_r;
  logic [7:0]       b0_r, b1_r, b2_r;
  logic             pend_valid_r;
  res_t             pend_r;
  logic             out_valid_r;
  res_t             out_r;
  logic             out_final_r;

  logic             out_free;
  logic             blocked;
  logic             go;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [7:0]       rd_byte;
  res_t             emit_res;
  logic             do_emit;
  logic             do_finish;

  assign out_free  = !out_valid_r || !out_stall;
  assign blocked   = pend_valid_r && !out_free &&
                     ((uword.emit != EM_NONE) || (uword.op == OP_FINISH));
  assign go        = !blocked;
  assign do_emit   = go && (uword.emit != EM_NONE);
  assign do_finish = go && (uword.op == OP_FINISH);

  assign in_stall = (uword.op != OP_ACCEPT);

  always_comb begin
    status.in_valid    = in_valid;
    status.started     = started_r;
    status.hdr_off     = !hdr_en_r;
    status.full        = (byte_count_r >= LINE_CNT);
    status.hdr_more    = (hdr_idx_r != 4'd0);
    status.is_eos      = (req_r == REQ_EOS);
    status.has_bytes   = (byte_count_r != '0);
    status.more_groups = (rd_idx_r < byte_count_r);
    status.blocked     = blocked;
  end

  // line buffer
  assign wr_en   = go && ((uword.op == OP_WR_HDR) || (uword.op == OP_WR_DATA));
  assign wr_data = (uword.op == OP_WR_HDR) ? hdr_byte(hdr_idx_r, addr_r) : data_r;
  assign rd_addr = (rd_idx_r < LINE_CNT) ? rd_idx_r[IDX_W-1:0] : '0;
  assign rd_byte = rd_ok_r ? rd_data : 8'h00;

  uue_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    emit_res = '0;
    case (uword.emit)
      EM_LEN: begin
        emit_res.a     = 8'(byte_count_r) + CH_BIAS;
        emit_res.count = CNT_ONE;
      end
      EM_GROUP: begin
        emit_res.a     = enc6(b0_r[7:2]);
        emit_res.b     = enc6({b0_r[1:0], b1_r[7:4]});
        emit_res.c     = enc6({b1_r[3:0], b2_r[7:6]});
        emit_res.d     = enc6(b2_r[5:0]);
        emit_res.count = CNT_FOUR;
      end
      EM_CRLF: begin
        emit_res.a     = CH_CR;
        emit_res.b     = CH_LF;
        emit_res.count = CNT_TWO;
      end
      EM_TRL1: begin
        emit_res.a     = CH_GRAVE;
        emit_res.b     = CH_CR;
        emit_res.c     = CH_LF;
        emit_res.count = CNT_THREE;
      end
      EM_TRL2: begin
        emit_res.a     = CH_E;
        emit_res.b     = CH_N;
        emit_res.c     = CH_D;
        emit_res.count = CNT_THREE;
      end
      EM_TRL3: begin
        emit_res.a     = CH_CR;
        emit_res.b     = CH_LF;
        emit_res.c     = CH_EOF;
        emit_res.count = CNT_THREE;
      end
      default: emit_res = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      byte_count_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (go) begin
        case (uword.op)
          OP_START:      started_r    <= 1'b1;
          OP_WR_HDR,
          OP_WR_DATA:    byte_count_r <= byte_count_r + CNT_W'(1);
          OP_CLR_COUNT:  byte_count_r <= '0;
          OP_END_STREAM: begin
            started_r    <= 1'b0;
            byte_count_r <= '0;
          end
          default: ;
        endcase
      end

      // a new result pushes the held one out, not the last; the end of a
      // transaction pushes the held one out marked last
      if ((do_emit || do_finish) && pend_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (do_emit) begin
        pend_valid_r <= 1'b1;
      end else if (do_finish) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_ok_r <= (rd_idx_r < byte_count_r);
    if (go) begin
      case (uword.op)
        OP_ACCEPT: begin
          if (in_valid) begin
            req_r  <= in_req_type;
            data_r <= in_data_byte;
          end
        end
        OP_START: begin
          hdr_en_r  <= cfg_hdr_en;
          addr_r    <= cfg_addr;
          hdr_idx_r <= 4'd0;
        end
        OP_WR_HDR:   hdr_idx_r <= hdr_idx_r + 4'd1;
        OP_RD_CLEAR: rd_idx_r  <= '0;
        OP_RD_NEXT:  rd_idx_r  <= rd_idx_r + CNT_W'(1);
        OP_CAP0: begin
          b0_r     <= rd_byte;
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        OP_CAP1: begin
          b1_r     <= rd_byte;
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        OP_CAP2: b2_r <= rd_byte;
        default: ;
      endcase
    end
    if (do_emit) begin
      pend_r <= emit_res;
      if (pend_valid_r) begin
        out_r       <= pend_r;
        out_final_r <= 1'b0;
      end
    end
    if (do_finish && pend_valid_r) begin
      out_r       <= pend_r;
      out_final_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_final = out_final_r;

endmodule

### tb/tb_uuencode_line_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_uuencode_line_encoder_core
// self-checking bench for the uuencode line encoder core
// ----------------------------------------------------------------------------
// Drives byte streams and end-of-stream markers into the encoder, mirrors the
// line buffer, header insertion and trailer in a scoreboard class and checks
// every output transaction against the oldest predicted character group.
// A directed opening covers empty streams, partial groups, the load header,
// address extremes and a register change in the middle of a stream; random
// streams then follow under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_uuencode_line_encoder_core
  import uue_pkg::*;
();

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [2:0] cnt;
    logic       fin;
  } char_group_t;

  class uu_line_scoreboard;
    bit [7:0]    line_buf [64];
    bit [7:0]    fill;
    bit          in_stream;
    bit          hdr_mode;
    bit [19:0]   load_addr;
    char_group_t expected_groups [$];
    int unsigned mismatches;

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_HDR_EN) begin
        hdr_mode = value[0];
      end else begin
        load_addr = value[19:0];
      end
    endfunction

    function bit [7:0] sixbit_char(bit [5:0] v);
      return (v == 6'd0) ? CH_GRAVE : ({2'b00, v} + CH_BIAS);
    endfunction

    function void add_group(bit [7:0] a, bit [7:0] b, bit [7:0] c, bit [7:0] d,
                            bit [2:0] n);
      char_group_t g;
      g = {a, b, c, d, n, 1'b0};
      expected_groups.push_back(g);
    endfunction

    function bit [7:0] slot_byte(bit [7:0] i);
      return (i < fill) ? line_buf[i[5:0]] : 8'h00;
    endfunction

    // length char, groups of four, CR LF
    function void flush_line();
      bit [7:0] i;
      bit [7:0] b0;
      bit [7:0] b1;
      bit [7:0] b2;
      if (fill == 0) return;
      add_group(fill + CH_BIAS, 8'h00, 8'h00, 8'h00, CNT_ONE);
      for (i = 8'd0; i < fill; i = i + 8'd3) begin
        b0 = slot_byte(i);
        b1 = slot_byte(i + 8'd1);
        b2 = slot_byte(i + 8'd2);
        add_group(sixbit_char(b0[7:2]), sixbit_char({b0[1:0], b1[7:4]}),
                  sixbit_char({b1[3:0], b2[7:6]}), sixbit_char(b2[5:0]), CNT_FOUR);
      end
      add_group(CH_CR, CH_LF, 8'h00, 8'h00, CNT_TWO);
      fill = 0;
    endfunction

    function void push_byte(bit [7:0] b);
      line_buf[fill[5:0]] = b;
      fill = fill + 8'd1;
      if (fill >= LINE_BYTES_DEF) flush_line();
    endfunction

    // registers are sampled here, at the first transaction of a stream
    function void open_stream();
      bit [7:0] hdr [16];
      int i;
      if (in_stream) return;
      in_stream = 1'b1;
      if (!hdr_mode) return;
      hdr = '{8'hff, 8'h00, 8'h06, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h0b, 8'hff, 8'hff, 8'hff, 8'h00, 8'h0f};
      hdr[5] = load_addr[7:0];
      hdr[6] = load_addr[15:8];
      for (i = 0; i < 16; i++) push_byte(hdr[i[3:0]]);
    endfunction

    function void absorb_item(logic req, logic [7:0] data);
      int          before_cnt;
      char_group_t last;
      before_cnt = expected_groups.size();
      open_stream();
      if (req != REQ_EOS) begin
        push_byte(data);
      end else begin
        flush_line();
        add_group(CH_GRAVE, CH_CR, CH_LF, 8'h00, CNT_THREE);
        add_group(CH_E, CH_N, CH_D, 8'h00, CNT_THREE);
        add_group(CH_CR, CH_LF, CH_EOF, 8'h00, CNT_THREE);
        fill = 0;
        in_stream = 1'b0;
      end
      if (expected_groups.size() > before_cnt) begin
        last = expected_groups.pop_back();
        last.fin = 1'b1;
        expected_groups.push_back(last);
      end
    endfunction

    function void compare_group(char_group_t got);
      char_group_t want;
      if (expected_groups.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: %h %h %h %h count %0d final %0d",
                   got.a, got.b, got.c, got.d, got.cnt, got.fin);
        mismatches++;
        return;
      end
      want = expected_groups.pop_front();
      if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
          got.d !== want.d || got.cnt !== want.cnt || got.fin !== want.fin) begin
        if (mismatches < 10) begin
          $write("mismatch: expected %h %h %h %h count %0d final %0d, ",
                 want.a, want.b, want.c, want.d, want.cnt, want.fin);
          $display("got %h %h %h %h count %0d final %0d",
                   got.a, got.b, got.c, got.d, got.cnt, got.fin);
        end
        mismatches++;
      end
    endfunction

    function void close_out();
      if (expected_groups.size() != 0) begin
        $display("%0d expected results never arrived", expected_groups.size());
        mismatches++;
      end
    endfunction
  endclass

  localparam logic REQ_DATA    = ~REQ_EOS;
  localparam int   PHASE_ITEMS = 100;   // random items per idling pattern
  localparam int   IDLE_PAUSE  = 120;   // covers a header start with no result
  localparam int   STUCK_LIMIT = 4000;  // cycles without any transaction

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [7:0]            in_data_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_char_a;
  logic [7:0]            out_char_b;
  logic [7:0]            out_char_c;
  logic [7:0]            out_char_d;
  logic [2:0]            out_char_count;
  logic                  out_final_of_run;

  uu_line_scoreboard sb;
  int unsigned       snd_idle_pct;
  int unsigned       rcv_idle_pct;
  int unsigned       items_sent;
  int unsigned       stuck_cycles;
  logic              cur_hdr;
  char_group_t       seen_group;

  uuencode_line_encoder_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_a       (out_char_a),
    .out_char_b       (out_char_b),
    .out_char_c       (out_char_c),
    .out_char_d       (out_char_d),
    .out_char_count   (out_char_count),
    .out_final_of_run (out_final_of_run)
  );

  always #5 clk = ~clk;

  // receiver side: random stall decided at each falling edge
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < rcv_idle_pct);
  end

  // monitor: transactions are taken at the rising edge, before any flop update
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.absorb_item(in_req_type, in_data_byte);
      if (out_valid && !out_stall) begin
        seen_group = {out_char_a, out_char_b, out_char_c, out_char_d,
                      out_char_count, out_final_of_run};
        sb.compare_group(seen_group);
      end
      // watchdog on cycles where neither channel moves
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL uuencode_line_encoder_core");
        $finish;
      end
    end
  end

  // one input transaction; entered and left at a falling edge, valid stays up
  task automatic send_item(input logic req, input logic [7:0] data);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid     = 1'b0;
      in_req_type  = 1'($urandom_range(1));
      in_data_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_req_type  = req;
    in_data_byte = data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_eos();
    send_item(REQ_EOS, 8'($urandom_range(255)));
  endtask

  // hold off input until every predicted group has come out
  task automatic wait_drained(input int pause);
    in_valid = 1'b0;
    while (sb.expected_groups.size() != 0) @(negedge clk);
    repeat (pause) @(negedge clk);
  endtask

  // setup cycle then access cycle; write lands when pready is seen high
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // registers only change once the block has gone quiet
  task automatic write_config(input logic [31:0] hdr_word, input logic [31:0] addr_word);
    wait_drained(IDLE_PAUSE);
    write_reg(REG_HDR_EN, hdr_word);
    write_reg(REG_LOAD_ADDR, addr_word);
    cur_hdr = hdr_word[0];
  endtask

  function automatic logic [31:0] pick_address();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;   // upper bits must be dropped
      default: return $urandom;
    endcase
  endfunction

  // stream length, biased toward short lines and exact line boundaries
  function automatic int pick_length();
    int hdr_bytes;
    hdr_bytes = cur_hdr ? HDR_LEN : 0;
    case ($urandom_range(9))
      0:       return 0;
      1:       return LINE_BYTES_DEF - hdr_bytes;
      2:       return 2 * LINE_BYTES_DEF - hdr_bytes;
      3, 4, 5: return $urandom_range(12, 1);
      6, 7:    return $urandom_range(44, 13);
      8:       return $urandom_range(100, 46);
      default: return $urandom_range(5, 1);
    endcase
  endfunction

  task automatic send_stream(input int nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case ($urandom_range(9))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(255));
      endcase
      send_item(REQ_DATA, b);
    end
    send_eos();
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_valid     = 1'b0;
    in_req_type  = REQ_DATA;
    in_data_byte = 8'h00;
    out_stall    = 1'b0;
    snd_idle_pct = 27;
    rcv_idle_pct = 69;
    items_sent   = 0;
    stuck_cycles = 0;
    cur_hdr      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed opening ----
    write_config(32'd0, 32'd0);
    send_eos();                          // empty stream, trailer only
    send_item(REQ_DATA, 8'h00);          // one full group, zero and all-ones bytes
    send_item(REQ_DATA, 8'hff);
    send_item(REQ_DATA, 8'h80);
    send_eos();
    send_item(REQ_DATA, 8'h01);          // single byte, two padded slots
    send_eos();
    send_item(REQ_DATA, 8'ha5);          // two bytes, one padded slot
    send_item(REQ_DATA, 8'h3c);
    send_eos();
    write_config(32'd1, 32'h000f_ffff);  // header on, top address
    send_eos();                          // empty stream still carries the header line
    send_item(REQ_DATA, 8'h55);
    send_item(REQ_DATA, 8'haa);
    send_eos();
    send_item(REQ_DATA, 8'h12);          // stream opens with header on
    write_config(32'd0, 32'h0001_2345);  // must not affect the open stream
    send_item(REQ_DATA, 8'h34);
    send_eos();
    send_item(REQ_DATA, 8'h00);          // new stream picks up the new settings
    send_eos();

    // ---- random streams under three idling patterns ----
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained(0);
      case (phase)
        0: begin
          snd_idle_pct = 27;
          rcv_idle_pct = 69;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_idle_pct = 27;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      write_config({$urandom_range(1)}, pick_address());
      begin : phase_loop
        int unsigned phase_end;
        phase_end = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end) begin
          send_stream(pick_length());
          // occasional register change between streams, or just a drain pause
          if ($urandom_range(99) < 15) begin
            write_config($urandom, pick_address());
          end else if ($urandom_range(99) < 10) begin
            wait_drained(0);
          end
        end
      end
    end

    // ---- drain and verdict ----
    in_valid = 1'b0;
    while (sb.expected_groups.size() != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("PASS uuencode_line_encoder_core");
    end else begin
      $display("FAIL uuencode_line_encoder_core");
    end
    $finish;
  end

endmodule

### uuencode_line_encoder_core.f
src/uue_pkg.sv
src/uue_ram.sv
src/uue_ctrl.sv
src/uue_datapath.sv
src/uuencode_line_encoder_core.sv
tb/tb_uuencode_line_encoder_core.sv
